@@ src/flood_relay_retransmit_scheduler_unit_defines.svh @@
// assertion macros shared by the scheduler checks
`ifndef FLOOD_RELAY_RETRANSMIT_SCHEDULER_UNIT_DEFINES_SVH
`define FLOOD_RELAY_RETRANSMIT_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication, checked at every clock edge out of reset
`define FRRS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FRRS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/frrs_pkg.sv @@
// types, codes and helpers of the flood relay retransmit scheduler
package frrs_pkg;

   localparam logic [3:0] MAX_REPEATS = 4'd8;

   localparam logic [1:0] OP_START   = 2'd0;
   localparam logic [1:0] OP_ATTEMPT = 2'd1;
   localparam logic [1:0] OP_REBASE  = 2'd2;

   localparam logic [1:0] OUTCOME_ACCEPTED = 2'd0;
   localparam logic [1:0] OUTCOME_BUSY     = 2'd1;

   localparam logic [2:0] ST_COMPLETE   = 3'd0;
   localparam logic [2:0] ST_SENT       = 3'd1;
   localparam logic [2:0] ST_AGAIN      = 3'd2;
   localparam logic [2:0] ST_WAITING    = 3'd3;
   localparam logic [2:0] ST_TIMEOUT    = 3'd4;
   localparam logic [2:0] ST_INVALID    = 3'd5;
   localparam logic [2:0] ST_SEND_ERROR = 3'd6;

   localparam logic [1:0] CSR_REPEAT_LIMIT = 2'd0;
   localparam logic [1:0] CSR_INTERVAL     = 2'd1;
   localparam logic [1:0] CSR_BACKOFF_MIN  = 2'd2;
   localparam logic [1:0] CSR_BACKOFF_MAX  = 2'd3;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECIDE,
      S_BACKOFF,
      S_RESP
   } ctl_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_DOUBLE,
      B_WINDOW,
      B_DIVIDE
   } bo_state_type;

   typedef struct packed {
      logic        start;
      logic [7:0]  step;
      logic [31:0] rnd;
   } bo_req_type;

   typedef struct packed {
      logic        done;
      logic [16:0] value;
   } bo_rsp_type;

   // t has reached mark under wrapping time
   function automatic logic reached(input logic [31:0] t, input logic [31:0] mark);
      logic [31:0] diff;
      diff = t - mark;
      return ~diff[31];
   endfunction

   function automatic logic [7:0] sat_inc8(input logic [7:0] c);
      return (c == 8'hFF) ? c : c + 8'd1;
   endfunction

   function automatic logic [31:0] clamp_due(input logic [31:0] d, input logic [31:0] dl,
                                             input logic on);
      return (on && reached(d, dl)) ? dl : d;
   endfunction

endpackage

@@ src/frrs_if.sv @@
// request and response channel interfaces
interface frrs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] now_ms;
   logic [31:0] time_a;
   logic        flag_a;
   logic [31:0] time_b;
   logic        flag_b;
   logic [31:0] cutoff_ms;
   logic        deadline_valid;
   logic        hold_off;
   logic        channel_quiet;
   logic [31:0] jitter_seed;
   logic [1:0]  send_outcome;

   modport source (output valid, op, now_ms, time_a, flag_a, time_b, flag_b, cutoff_ms,
                   deadline_valid, hold_off, channel_quiet, jitter_seed, send_outcome,
                   input ready);
   modport sink (input valid, op, now_ms, time_a, flag_a, time_b, flag_b, cutoff_ms,
                 deadline_valid, hold_off, channel_quiet, jitter_seed, send_outcome,
                 output ready);
endinterface

interface frrs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        send_issued;
   logic [31:0] attempt_age_ms;
   logic [7:0]  send_total;
   logic [7:0]  defer_total;
   logic [7:0]  skip_total;
   logic [31:0] next_due_ms;

   modport source (output valid, status, send_issued, attempt_age_ms, send_total,
                   defer_total, skip_total, next_due_ms, input ready);
   modport sink (input valid, status, send_issued, attempt_age_ms, send_total,
                 defer_total, skip_total, next_due_ms, output ready);
endinterface

@@ src/frrs_backoff.sv @@
// iterative backoff unit: doubling sequence then bit-serial jitter remainder
module frrs_backoff
   import frrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  bo_req_type  req,
   input  logic [15:0] backoff_min,
   input  logic [15:0] backoff_max,
   output bo_rsp_type  rsp
);

   bo_state_type state_ff, state_in;
   logic [15:0] base_ff, base_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [7:0]  step_ff, step_in;
   logic [15:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [15:0] div_ff, div_in;
   logic [4:0]  bit_ff, bit_in;
   logic        done_ff, done_in;
   logic [16:0] value_ff, value_in;

   logic [15:0] capped;
   logic [15:0] win;
   logic [16:0] trial;
   logic [15:0] rem_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      base_ff  <= base_in;
      cnt_ff   <= cnt_in;
      step_ff  <= step_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      div_ff   <= div_in;
      bit_ff   <= bit_in;
      value_ff <= value_in;
   end

   always_comb begin
      state_in = state_ff;
      base_in  = base_ff;
      cnt_in   = cnt_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      bit_in   = bit_ff;
      done_in  = 1'b0;
      value_in = value_ff;
      capped   = (base_ff > backoff_max) ? backoff_max : base_ff;
      win      = backoff_max - capped;
      if (win >= capped) begin
         win = capped - 16'd1;
      end
      trial    = {rem_ff, quo_ff[31]};
      rem_next = (trial >= {1'b0, div_ff}) ? 16'(trial - {1'b0, div_ff}) : trial[15:0];
      unique case (state_ff)
         B_IDLE: begin
            if (req.start) begin
               base_in  = backoff_min;
               cnt_in   = 8'd0;
               step_in  = req.step;
               quo_in   = req.rnd;
               state_in = B_DOUBLE;
            end
         end
         B_DOUBLE: begin
            priority if (cnt_ff == step_ff) begin
               state_in = B_WINDOW;
            end else if (base_ff >= (backoff_max >> 1)) begin
               base_in  = backoff_max;
               state_in = B_WINDOW;
            end else if (base_ff == 16'd0) begin
               // doubling zero goes nowhere
               state_in = B_WINDOW;
            end else begin
               base_in = base_ff << 1;
               cnt_in  = cnt_ff + 8'd1;
            end
         end
         B_WINDOW: begin
            priority if (capped == 16'd0) begin
               value_in = 17'd0;
               done_in  = 1'b1;
               state_in = B_IDLE;
            end else if (win == 16'd0) begin
               value_in = {1'b0, capped};
               done_in  = 1'b1;
               state_in = B_IDLE;
            end else begin
               base_in  = capped;
               div_in   = win + 16'd1;
               rem_in   = 16'd0;
               bit_in   = 5'd0;
               state_in = B_DIVIDE;
            end
         end
         B_DIVIDE: begin
            rem_in = rem_next;
            quo_in = quo_ff << 1;
            bit_in = bit_ff + 5'd1;
            if (bit_ff == 5'd31) begin
               value_in = {1'b0, base_ff} + {1'b0, rem_next};
               done_in  = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   assign rsp.done  = done_ff;
   assign rsp.value = value_ff;

endmodule

@@ src/flood_relay_retransmit_scheduler_unit.sv @@
// flood relay retransmit scheduler: one message's repeated transmissions
//
// req carries one item per handshake (valid and ready high at a clock edge):
// start, attempt or rebase, plus the sampled time, defer, quiet, random
// and send-outcome inputs. rsp returns exactly one result item per request.
// csr_* writes the four configuration registers; the user must write them
// only while the block is idle, which the block itself does not enforce.
// Start, rebase and most attempts pass from idle through decide to resp;
// an attempt that backs off first runs the shared backoff unit, which doubles
// the base step by step, forms the window and takes a 32-bit bit-serial remainder.
// One item is in work at a time; req.ready is high only in the idle state,
// so a new item is taken only once the last one has reached the output register.
// The result sits in an output register, so the next item may be taken
// while rsp waits; if rsp stalls, a finished item holds until it drains.
// Synchronous reset clears the control state, timing, counters and rsp valid
// to zero and loads the register defaults (limit 8, interval 100, backoff 10 to 1000).
module flood_relay_retransmit_scheduler_unit
   import frrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   frrs_req_if.sink    req,
   frrs_rsp_if.source  rsp,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   ctl_state_type state_ff, state_in;

   logic [3:0]  limit_ff;
   logic [15:0] interval_ff, bmin_ff, bmax_ff;

   logic [31:0] due_ff, due_in;
   logic [31:0] origin_ff, origin_in;
   logic [31:0] dl_ff, dl_in;
   logic        dl_on_ff, dl_on_in;
   logic        started_ff, started_in;
   logic        finished_ff, finished_in;
   logic [3:0]  opp_ff, opp_in;
   logic [7:0]  step_ff, step_in;
   logic [7:0]  sends_ff, sends_in;
   logic [7:0]  defers_ff, defers_in;
   logic [7:0]  busy_ff, busy_in;

   // latched item
   logic [1:0]  op_ff;
   logic [31:0] now_ff, ta_ff, tb_ff, dlm_ff, rnd_ff;
   logic        fa_ff, fb_ff, dlv_ff, defer_ff, quiet_ff;
   logic [1:0]  outcome_ff;

   logic [2:0]  status_ff, status_in;
   logic        issued_ff, issued_in;
   logic [31:0] age_ff, age_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff;
   logic        rsp_issued_ff;
   logic [31:0] rsp_age_ff, rsp_due_ff;
   logic [7:0]  rsp_sent_ff, rsp_def_ff, rsp_busy_ff;
   logic        rsp_load;

   bo_req_type  bo_req;
   bo_rsp_type  bo_rsp;

   logic [31:0] elapsed;
   logic [32:0] age_sum;
   logic [31:0] due_sent;
   logic [3:0]  opp_sent;
   logic        accept;

   assign accept = req.valid && req.ready;

   frrs_backoff u_backoff (
      .clock       (clock),
      .reset       (reset),
      .req         (bo_req),
      .backoff_min (bmin_ff),
      .backoff_max (bmax_ff),
      .rsp         (bo_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= 4'd8;
         interval_ff <= 16'd100;
         bmin_ff     <= 16'd10;
         bmax_ff     <= 16'd1000;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_REPEAT_LIMIT: limit_ff    <= csr_write_data[3:0];
            CSR_INTERVAL:     interval_ff <= csr_write_data;
            CSR_BACKOFF_MIN:  bmin_ff     <= csr_write_data;
            CSR_BACKOFF_MAX:  bmax_ff     <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         due_ff       <= 32'd0;
         origin_ff    <= 32'd0;
         dl_ff        <= 32'd0;
         dl_on_ff     <= 1'b0;
         started_ff   <= 1'b0;
         finished_ff  <= 1'b0;
         opp_ff       <= 4'd0;
         step_ff      <= 8'd0;
         sends_ff     <= 8'd0;
         defers_ff    <= 8'd0;
         busy_ff      <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         due_ff       <= due_in;
         origin_ff    <= origin_in;
         dl_ff        <= dl_in;
         dl_on_ff     <= dl_on_in;
         started_ff   <= started_in;
         finished_ff  <= finished_in;
         opp_ff       <= opp_in;
         step_ff      <= step_in;
         sends_ff     <= sends_in;
         defers_ff    <= defers_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req.op;
         now_ff     <= req.now_ms;
         ta_ff      <= req.time_a;
         fa_ff      <= req.flag_a;
         tb_ff      <= req.time_b;
         fb_ff      <= req.flag_b;
         dlm_ff     <= req.cutoff_ms;
         dlv_ff     <= req.deadline_valid;
         defer_ff   <= req.hold_off;
         quiet_ff   <= req.channel_quiet;
         rnd_ff     <= req.jitter_seed;
         outcome_ff <= req.send_outcome;
      end
      status_ff <= status_in;
      issued_ff <= issued_in;
      age_ff    <= age_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_issued_ff <= issued_ff;
         rsp_age_ff    <= age_ff;
         rsp_sent_ff   <= sends_ff;
         rsp_def_ff    <= defers_ff;
         rsp_busy_ff   <= busy_ff;
         rsp_due_ff    <= due_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      due_in       = due_ff;
      origin_in    = origin_ff;
      dl_in        = dl_ff;
      dl_on_in     = dl_on_ff;
      started_in   = started_ff;
      finished_in  = finished_ff;
      opp_in       = opp_ff;
      step_in      = step_ff;
      sends_in     = sends_ff;
      defers_in    = defers_ff;
      busy_in      = busy_ff;
      status_in    = status_ff;
      issued_in    = issued_ff;
      age_in       = age_ff;
      bo_req.start = 1'b0;
      bo_req.step  = step_ff;
      bo_req.rnd   = rnd_ff;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;

      elapsed  = now_ff - origin_ff;
      age_sum  = {1'b0, ta_ff} + {1'b0, elapsed};
      due_sent = clamp_due(now_ff + {16'd0, interval_ff}, dl_ff, dl_on_ff);
      opp_sent = opp_ff + 4'd1;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in  = S_RESP;
            issued_in = 1'b0;
            age_in    = 32'd0;
            status_in = ST_INVALID;
            if (op_ff == OP_START) begin
               due_in      = fa_ff ? ta_ff : now_ff;
               origin_in   = fb_ff ? tb_ff : (fa_ff ? ta_ff : now_ff);
               dl_in       = dlm_ff;
               dl_on_in    = dlv_ff;
               started_in  = 1'b1;
               finished_in = 1'b0;
               opp_in      = 4'd0;
               step_in     = 8'd0;
               sends_in    = 8'd0;
               defers_in   = 8'd0;
               busy_in     = 8'd0;
               status_in   = ST_WAITING;
            end else if (op_ff == OP_REBASE) begin
               if (started_ff && !finished_ff) begin
                  due_in    = due_ff + ta_ff;
                  status_in = ST_WAITING;
               end
            end else if (op_ff == OP_ATTEMPT) begin
               priority if (!started_ff || limit_ff == 4'd0 || limit_ff > MAX_REPEATS ||
                            interval_ff == 16'd0) begin
                  status_in = ST_INVALID;
               end else if (finished_ff) begin
                  status_in = (sends_ff != 8'd0) ? ST_COMPLETE : ST_AGAIN;
               end else if (dl_on_ff && reached(now_ff, dl_ff)) begin
                  status_in = ST_TIMEOUT;
               end else if (opp_ff >= limit_ff) begin
                  finished_in = 1'b1;
                  status_in   = (sends_ff != 8'd0) ? ST_COMPLETE : ST_AGAIN;
               end else if (defer_ff) begin
                  defers_in = sat_inc8(defers_ff);
                  status_in = ST_AGAIN;
               end else if (!reached(now_ff, due_ff)) begin
                  status_in = (dl_on_ff && reached(due_ff, dl_ff)) ? ST_TIMEOUT : ST_WAITING;
               end else if (!quiet_ff) begin
                  bo_req.start = 1'b1;
                  state_in     = S_BACKOFF;
               end else begin
                  issued_in = 1'b1;
                  age_in    = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
                  priority if (outcome_ff == OUTCOME_BUSY) begin
                     bo_req.start = 1'b1;
                     state_in     = S_BACKOFF;
                  end else if (outcome_ff != OUTCOME_ACCEPTED) begin
                     status_in = ST_SEND_ERROR;
                  end else begin
                     opp_in   = opp_sent;
                     sends_in = sat_inc8(sends_ff);
                     step_in  = 8'd0;
                     due_in   = due_sent;
                     priority if (opp_sent >= limit_ff) begin
                        finished_in = 1'b1;
                        status_in   = ST_COMPLETE;
                     end else if (dl_on_ff && reached(due_sent, dl_ff)) begin
                        status_in = ST_TIMEOUT;
                     end else begin
                        status_in = ST_SENT;
                     end
                  end
               end
            end
         end
         S_BACKOFF: begin
            if (bo_rsp.done) begin
               busy_in   = sat_inc8(busy_ff);
               due_in    = clamp_due(now_ff + {15'd0, bo_rsp.value}, dl_ff, dl_on_ff);
               step_in   = sat_inc8(step_ff);
               status_in = ST_AGAIN;
               state_in  = S_RESP;
            end
         end
         S_RESP: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req.ready          = (state_ff == S_IDLE);
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = rsp_status_ff;
   assign rsp.send_issued    = rsp_issued_ff;
   assign rsp.attempt_age_ms = rsp_age_ff;
   assign rsp.send_total     = rsp_sent_ff;
   assign rsp.defer_total    = rsp_def_ff;
   assign rsp.skip_total     = rsp_busy_ff;
   assign rsp.next_due_ms    = rsp_due_ff;

endmodule

@@ src/frrs_checker.sv @@
// port-level checks of the scheduler and their bind
`include "flood_relay_retransmit_scheduler_unit_defines.svh"

module frrs_checker
   import frrs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic        rsp_send_issued,
   input logic [31:0] rsp_attempt_age_ms
);

   `FRRS_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")
   `FRRS_ASSERT_NEXT(a_rsp_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status), "rsp dropped")
   `FRRS_ASSERT_SAME(a_no_send_on_wait, rsp_valid && (rsp_status == ST_WAITING || rsp_status == ST_INVALID), !rsp_send_issued, "send on wait")
   `FRRS_ASSERT_SAME(a_age_zero, rsp_valid && !rsp_send_issued, rsp_attempt_age_ms == 32'd0, "age without send")

endmodule

bind flood_relay_retransmit_scheduler_unit frrs_checker u_frrs_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req.valid),
   .req_ready          (req.ready),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_status         (rsp.status),
   .rsp_send_issued    (rsp.send_issued),
   .rsp_attempt_age_ms (rsp.attempt_age_ms)
);
